FILE: sv/sha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [255:0] IvAll = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  typedef struct packed {
    logic start;
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: sv/sha_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round per cycle over a rolling 16-word schedule window.
// ----------------------------------------------------------------------------
module sha_round import sha_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire rnd_ctl_t     ctl_i,
  input  wire logic [511:0] block_i,
  input  wire logic [255:0] hash_i,
  output logic              done_o,
  output logic [255:0]      hash_o
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic        run_q;
  logic        done_q;
  logic [31:0] s0, s1, wn, big1, ch, t1, big0, maj, t2;

  always_comb begin
    s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wn   = w_q[0] + s0 + w_q[9] + s1;
    big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
    big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[511-32*i -: 32];
      for (int i = 0; i < 8; i++) v_q[i] <= hash_i[255-32*i -: 32];
    end else if (run_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      for (int i = 1; i < 8; i++) if (i != 4) v_q[i] <= v_q[i-1];
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

  assign done_o = done_q;
  always_comb
    for (int i = 0; i < 8; i++) hash_o[255-32*i -: 32] = hash_i[255-32*i -: 32] + v_q[i];

endmodule
`default_nettype wire

FILE: sv/sha256_message_digest_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message digest core
// Absorb bytes, pad on finish and emit eight digest words.
// ----------------------------------------------------------------------------
// Absorb: one byte per cycle while idle; the byte that fills a block stalls the
//   input while the 64 rounds run.
// Finish: pad bytes one per cycle, pausing while the rounds run on each block
//   (one or two), then eight output words, one per cycle when not stalled.
// Rounds run one per cycle in the shared round unit.
// Reset (async, active low) restores initial hash, zero count and length.
module sha256_message_digest_core import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  localparam logic [2:0] StIdle = 3'd0, StComp = 3'd1, StPad = 3'd2,
                         StLen = 3'd3, StOut = 3'd4;

  logic [2:0]   state_q;
  logic         padding_q;
  logic [5:0]   fill_q;
  logic [63:0]  bits_q, len_q;
  logic [255:0] hash_q;
  logic [511:0] buf_q;
  logic [2:0]   idx_q;
  logic         start_q;
  logic         done;
  logic [255:0] hash_new;
  logic         acc;
  logic         push;
  logic [7:0]   push_byte;
  rnd_ctl_t     ctl;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign ctl.start = start_q;

  sha_round u_round (
    .clk_i, .rst_ni, .ctl_i(ctl), .block_i(buf_q), .hash_i(hash_q),
    .done_o(done), .hash_o(hash_new)
  );

  always_comb begin
    push = 1'b0;
    push_byte = data_byte_i;
    case (state_q)
      StIdle: begin
        push = acc;
        push_byte = command_i ? PadByte : data_byte_i;
      end
      StPad: begin
        push = 1'b1;
        push_byte = 8'h00;
      end
      StLen: begin
        push = 1'b1;
        push_byte = len_q[63:56];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[511 - 8*fill_q -: 8] <= push_byte;
    if (acc) len_q <= bits_q;
    else if (state_q == StLen) len_q <= {len_q[55:0], 8'h00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; padding_q <= 1'b0; fill_q <= '0; bits_q <= '0;
      hash_q <= IvAll; idx_q <= '0; start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (push) begin
        fill_q <= fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          start_q <= 1'b1;
          state_q <= StComp;
        end else if (state_q == StIdle && command_i) begin
          state_q <= (fill_q + 6'd1 == LenOffset) ? StLen : StPad;
        end else if (state_q == StPad && fill_q + 6'd1 == LenOffset) begin
          state_q <= StLen;
        end
      end
      if (acc && command_i) padding_q <= 1'b1;
      if (acc && !command_i) bits_q <= bits_q + 64'd8;
      if (state_q == StComp && done) begin
        hash_q <= hash_new;
        if (!padding_q) state_q <= StIdle;
        else if (fill_q == 6'd0 && idx_q == 3'd1) begin
          state_q <= StOut;
          idx_q <= '0;
        end else state_q <= StPad;
      end
      if (state_q == StLen && fill_q == 6'd63) idx_q <= 3'd1;
      if (state_q == StOut && !out_stall_i) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          state_q <= StIdle; padding_q <= 1'b0; bits_q <= '0;
          hash_q <= IvAll; fill_q <= '0;
        end
      end
    end
  end

  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = hash_q[255 - 32*idx_q -: 32];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

`ifndef SYNTH
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut) else $error("output outside emit phase");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> in_stall_o) else $error("input accepted during rounds");
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !out_valid_o)
    else $error("extra digest word");
`endif

endmodule
`default_nettype wire
